// ===== hdl/clc_pkg.sv =====
// Shared constants, codes and types for the circular list with cursor.
// No dependencies; imported by the top level.
package clc_pkg;

    localparam int SLOTS         = 64;
    localparam int SLOT_BITS     = $clog2(SLOTS);
    localparam int COUNT_BITS    = $clog2(SLOTS + 1);
    localparam int KEY_BITS      = 32;
    localparam int DURATION_BITS = 16;
    localparam int ENTRY_BITS    = 2 * KEY_BITS + DURATION_BITS;
    localparam int MODE_BITS     = 3;
    localparam int STATUS_BITS   = 2;

    typedef logic [SLOT_BITS-1:0]     slot_t;
    typedef logic [COUNT_BITS-1:0]    count_t;
    typedef logic [KEY_BITS-1:0]      key_t;
    typedef logic [DURATION_BITS-1:0] dur_t;
    typedef logic [MODE_BITS-1:0]     mode_t;
    typedef logic [STATUS_BITS-1:0]   status_t;

    // command modes
    localparam mode_t MODE_APPEND  = 3'd0;
    localparam mode_t MODE_REMOVE  = 3'd1;
    localparam mode_t MODE_RESTART = 3'd2;
    localparam mode_t MODE_NEXT    = 3'd3;
    localparam mode_t MODE_PREV    = 3'd4;

    // result status codes
    localparam status_t ST_OK      = 2'd0;
    localparam status_t ST_EMPTY   = 2'd1;
    localparam status_t ST_MISSING = 2'd2;
    localparam status_t ST_FULL    = 2'd3;

endpackage

// ===== hdl/clc_ram.sv =====
// Generic single-port-write, single-port-read synchronous RAM.
// Read data is registered. No dependencies.
module clc_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64,
    parameter int ADDR_BITS = $clog2(DEPTH)
) (
    input  logic                 clk,
    input  logic                 we,
    input  logic [ADDR_BITS-1:0] waddr,
    input  logic [WIDTH-1:0]     wdata,
    input  logic [ADDR_BITS-1:0] raddr,
    output logic [WIDTH-1:0]     rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // write port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // registered read port
    always_ff @(posedge clk)
    begin
        rdata <= mem[raddr];
    end

endmodule

// ===== hdl/circular_list_with_cursor.sv =====
// Circular list with cursor: a ring of up to SLOTS songs kept in insertion
// order as a doubly linked list in on-chip RAM, with a head and a play cursor.
// Depends on clc_pkg and clc_ram.
//
// A command is taken when start is high and busy is low. Its single result
// appears on the result ports with done high for exactly one cycle, and the
// receiver cannot hold it off. busy drops in the cycle done is high, so the
// next command can be taken there. Restart, unknown modes and any command
// refused on an empty or full ring go straight to the fetch of the entry under
// the cursor and the reply; next and previous first move the cursor along one
// link. Append scans for the lowest free slot, one slot-used flag per cycle,
// and links the new entry in after the tail unless the ring was empty. Remove
// on a non-empty ring walks from head, reading one entry per cycle through the
// key and link RAMs. No clearing pass is needed after reset.
module circular_list_with_cursor
    import clc_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    start,
    output logic    busy,
    input  mode_t   mode,
    input  key_t    song_key,
    input  key_t    artist_key,
    input  dur_t    duration_seconds,
    output logic    done,
    output status_t status,
    output count_t  entry_count,
    output logic    cursor_valid,
    output key_t    cursor_song_key,
    output key_t    cursor_artist_key,
    output dur_t    cursor_duration
);

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_FIND  = 3'd1;
    localparam logic [2:0] S_LINK1 = 3'd2;
    localparam logic [2:0] S_LINK2 = 3'd3;
    localparam logic [2:0] S_WALK  = 3'd4;
    localparam logic [2:0] S_STEP  = 3'd5;
    localparam logic [2:0] S_FETCH = 3'd6;
    localparam logic [2:0] S_REPLY = 3'd7;

    // control state
    logic [2:0]       state_reg, state_next;
    slot_t            head_reg, head_next;
    slot_t            cursor_reg, cursor_next;
    count_t           count_reg, count_next;
    logic [SLOTS-1:0] used_reg, used_next;
    logic             done_reg, done_next;

    // per-command working registers
    slot_t            idx_reg, idx_next;
    slot_t            walk_reg, walk_next;
    count_t           step_reg, step_next;
    status_t          status_reg, status_next;
    mode_t            mode_reg;
    key_t             key_reg;
    key_t             artist_reg;
    dur_t             dur_reg;

    // result payload
    status_t          res_status_reg;
    key_t             res_key_reg;
    key_t             res_artist_reg;
    dur_t             res_dur_reg;

    // RAM ports
    slot_t                 rd_addr;
    logic                  data_we;
    logic [ENTRY_BITS-1:0] data_wdata;
    logic [ENTRY_BITS-1:0] data_rdata;
    logic                  fwd_we, bwd_we;
    slot_t                 fwd_waddr, bwd_waddr;
    slot_t                 fwd_wdata, bwd_wdata;
    slot_t                 fwd_rdata, bwd_rdata;

    key_t rd_key;
    key_t rd_artist;
    dur_t rd_dur;
    logic accept;

    assign accept     = start && !busy;
    assign data_wdata = {key_reg, artist_reg, dur_reg};
    assign rd_key     = data_rdata[ENTRY_BITS-1 -: KEY_BITS];
    assign rd_artist  = data_rdata[DURATION_BITS +: KEY_BITS];
    assign rd_dur     = data_rdata[DURATION_BITS-1:0];

    // entry, forward-link and backward-link stores share one read address
    clc_ram #(.WIDTH(ENTRY_BITS), .DEPTH(SLOTS)) u_data_ram (
        .clk   (clk),
        .we    (data_we),
        .waddr (idx_reg),
        .wdata (data_wdata),
        .raddr (rd_addr),
        .rdata (data_rdata)
    );

    clc_ram #(.WIDTH(SLOT_BITS), .DEPTH(SLOTS)) u_fwd_ram (
        .clk   (clk),
        .we    (fwd_we),
        .waddr (fwd_waddr),
        .wdata (fwd_wdata),
        .raddr (rd_addr),
        .rdata (fwd_rdata)
    );

    clc_ram #(.WIDTH(SLOT_BITS), .DEPTH(SLOTS)) u_bwd_ram (
        .clk   (clk),
        .we    (bwd_we),
        .waddr (bwd_waddr),
        .wdata (bwd_wdata),
        .raddr (rd_addr),
        .rdata (bwd_rdata)
    );

    // command sequencer
    always_comb
    begin
        state_next  = state_reg;
        head_next   = head_reg;
        cursor_next = cursor_reg;
        count_next  = count_reg;
        used_next   = used_reg;
        done_next   = 1'b0;
        idx_next    = idx_reg;
        walk_next   = walk_reg;
        step_next   = step_reg;
        status_next = status_reg;
        rd_addr     = cursor_reg;
        data_we     = 1'b0;
        fwd_we      = 1'b0;
        fwd_waddr   = idx_reg;
        fwd_wdata   = idx_reg;
        bwd_we      = 1'b0;
        bwd_waddr   = idx_reg;
        bwd_wdata   = idx_reg;

        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    status_next = ST_OK;
                    case (mode)
                        MODE_APPEND:
                        begin
                            idx_next = '0;
                            if (count_reg == count_t'(SLOTS))
                            begin
                                status_next = ST_FULL;
                                state_next  = S_FETCH;
                            end
                            else
                            begin
                                state_next = S_FIND;
                            end
                        end
                        MODE_REMOVE:
                        begin
                            if (count_reg == '0)
                            begin
                                status_next = ST_EMPTY;
                                state_next  = S_FETCH;
                            end
                            else
                            begin
                                rd_addr    = head_reg;
                                walk_next  = head_reg;
                                step_next  = '0;
                                state_next = S_WALK;
                            end
                        end
                        MODE_RESTART, MODE_NEXT, MODE_PREV:
                        begin
                            if (count_reg == '0)
                            begin
                                status_next = ST_EMPTY;
                                state_next  = S_FETCH;
                            end
                            else if (mode == MODE_RESTART)
                            begin
                                cursor_next = head_reg;
                                state_next  = S_FETCH;
                            end
                            else
                            begin
                                state_next = S_STEP;
                            end
                        end
                        default:
                        begin
                            state_next = S_FETCH;
                        end
                    endcase
                end
            end

            // scan for the lowest free slot, then store the entry there
            S_FIND:
            begin
                rd_addr = head_reg;
                if (used_reg[idx_reg])
                begin
                    idx_next = idx_reg + slot_t'(1);
                end
                else
                begin
                    data_we            = 1'b1;
                    used_next[idx_reg] = 1'b1;
                    if (count_reg == '0)
                    begin
                        // first entry links to itself
                        fwd_we      = 1'b1;
                        bwd_we      = 1'b1;
                        head_next   = idx_reg;
                        cursor_next = idx_reg;
                        count_next  = count_reg + count_t'(1);
                        state_next  = S_FETCH;
                    end
                    else
                    begin
                        state_next = S_LINK1;
                    end
                end
            end

            // tail = bwd[head]: tail -> new, new <- tail
            S_LINK1:
            begin
                fwd_we     = 1'b1;
                fwd_waddr  = bwd_rdata;
                fwd_wdata  = idx_reg;
                bwd_we     = 1'b1;
                bwd_waddr  = idx_reg;
                bwd_wdata  = bwd_rdata;
                state_next = S_LINK2;
            end

            // new -> head, head <- new
            S_LINK2:
            begin
                fwd_we     = 1'b1;
                fwd_waddr  = idx_reg;
                fwd_wdata  = head_reg;
                bwd_we     = 1'b1;
                bwd_waddr  = head_reg;
                bwd_wdata  = idx_reg;
                count_next = count_reg + count_t'(1);
                state_next = S_FETCH;
            end

            // one entry per cycle; next read follows the forward link
            S_WALK:
            begin
                if (rd_key == key_reg)
                begin
                    used_next[walk_reg] = 1'b0;
                    if (count_reg == count_t'(1))
                    begin
                        head_next   = '0;
                        cursor_next = '0;
                    end
                    else
                    begin
                        fwd_we    = 1'b1;
                        fwd_waddr = bwd_rdata;
                        fwd_wdata = fwd_rdata;
                        bwd_we    = 1'b1;
                        bwd_waddr = fwd_rdata;
                        bwd_wdata = bwd_rdata;
                        if (head_reg == walk_reg)
                        begin
                            head_next = fwd_rdata;
                        end
                        if (cursor_reg == walk_reg)
                        begin
                            cursor_next = fwd_rdata;
                        end
                    end
                    count_next = count_reg - count_t'(1);
                    state_next = S_FETCH;
                end
                else if ((step_reg + count_t'(1)) == count_reg)
                begin
                    status_next = ST_MISSING;
                    state_next  = S_FETCH;
                end
                else
                begin
                    rd_addr   = fwd_rdata;
                    walk_next = fwd_rdata;
                    step_next = step_reg + count_t'(1);
                end
            end

            // cursor moves along one link
            S_STEP:
            begin
                if (mode_reg == MODE_NEXT)
                begin
                    cursor_next = fwd_rdata;
                end
                else
                begin
                    cursor_next = bwd_rdata;
                end
                state_next = S_FETCH;
            end

            // read the entry under the final cursor
            S_FETCH:
            begin
                state_next = S_REPLY;
            end

            S_REPLY:
            begin
                done_next  = 1'b1;
                state_next = S_IDLE;
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_IDLE;
            head_reg   <= '0;
            cursor_reg <= '0;
            count_reg  <= '0;
            used_reg   <= '0;
            done_reg   <= 1'b0;
            idx_reg    <= '0;
            walk_reg   <= '0;
            step_reg   <= '0;
            status_reg <= ST_OK;
        end
        else
        begin
            state_reg  <= state_next;
            head_reg   <= head_next;
            cursor_reg <= cursor_next;
            count_reg  <= count_next;
            used_reg   <= used_next;
            done_reg   <= done_next;
            idx_reg    <= idx_next;
            walk_reg   <= walk_next;
            step_reg   <= step_next;
            status_reg <= status_next;
        end
    end

    // command capture and result payload
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            mode_reg   <= mode;
            key_reg    <= song_key;
            artist_reg <= artist_key;
            dur_reg    <= duration_seconds;
        end
        if (state_reg == S_REPLY)
        begin
            res_status_reg <= status_reg;
            if (count_reg != '0)
            begin
                res_key_reg    <= rd_key;
                res_artist_reg <= rd_artist;
                res_dur_reg    <= rd_dur;
            end
            else
            begin
                res_key_reg    <= '0;
                res_artist_reg <= '0;
                res_dur_reg    <= '0;
            end
        end
    end

    // count and cursor validity hold still while the result is shown
    assign busy              = (state_reg != S_IDLE);
    assign done              = done_reg;
    assign status            = res_status_reg;
    assign entry_count       = count_reg;
    assign cursor_valid      = (count_reg != '0);
    assign cursor_song_key   = res_key_reg;
    assign cursor_artist_key = res_artist_reg;
    assign cursor_duration   = res_dur_reg;

endmodule
